// ===== hw/rtl/direct_mapped_key_value_table_defines.svh =====
// ---------------------------------------------------------------------------
// direct_mapped_key_value_table_defines
// Assertion macros for the key/value table checker.
// ---------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_KEY_VALUE_TABLE_DEFINES_SVH
`define DIRECT_MAPPED_KEY_VALUE_TABLE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define KVT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kvt assertion failed");

// next-cycle implication, disabled during reset
`define KVT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kvt assertion failed");

`endif

// ===== hw/rtl/kvt_pkg.sv =====
// ---------------------------------------------------------------------------
// kvt_pkg
// Shared types, codes and the key conversion for the key/value table.
// ---------------------------------------------------------------------------
package kvt_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int CNT_W       = 11;
	localparam int WORD_W      = 129;
	localparam logic [CNT_W-1:0] ENTRIES_RST = 11'd1024;

	typedef enum logic [1:0] {
		CMD_GET     = 2'd0,
		CMD_GET_CHK = 2'd1,
		CMD_SET     = 2'd2,
		CMD_UPDATE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_ENTRIES = 2'd0,
		CFG_POW2    = 2'd1,
		CFG_NULL    = 2'd2,
		CFG_NONE    = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic conv;
		logic mask_slot;
		logic div_start;
		logic div_step;
		logic rd;
		logic exec;
	} dp_cmd_t;

	typedef struct packed {
		logic pow2;
		logic div_last;
		logic clear_last;
		logic out_free;
	} dp_stat_t;

	// double to unsigned 64-bit, truncating, with saturation
	function automatic logic [63:0] key_to_uint(logic [63:0] bits);
		logic [10:0] expo;
		logic [51:0] frac;
		logic [10:0] e;
		logic [63:0] mant;
		logic [63:0] res;
		expo = bits[62:52];
		frac = bits[51:0];
		e    = expo - 11'd1023;
		mant = {11'd0, 1'b1, frac};
		if (expo == 11'h7FF) begin
			res = (frac != 52'd0 || bits[63]) ? 64'd0 : '1;
		end else if (bits[63] || expo < 11'd1023) begin
			res = 64'd0;
		end else if (e >= 11'd64) begin
			res = '1;
		end else if (e >= 11'd52) begin
			res = mant << 6'(e - 11'd52);
		end else begin
			res = mant >> 6'(11'd52 - e);
		end
		return res;
	endfunction

endpackage

// ===== hw/rtl/kvt_ram.sv =====
// ---------------------------------------------------------------------------
// kvt_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module kvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/kvt_ctrl.sv =====
// ---------------------------------------------------------------------------
// kvt_ctrl
// Sequencer for the key/value table: clearing pass, slot derivation,
// table access and result hand-off.
// ---------------------------------------------------------------------------
module kvt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  kvt_pkg::dp_stat_t stat,
	output kvt_pkg::dp_cmd_t  cmd
);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_CONV  = 7'b0000100,
		ST_SLOT  = 7'b0001000,
		ST_DIV   = 7'b0010000,
		ST_READ  = 7'b0100000,
		ST_EXEC  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.conv = 1'b1;
				state_d  = ST_SLOT;
			end
			ST_SLOT: begin
				if (stat.pow2) begin
					cmd.mask_slot = 1'b1;
					state_d       = ST_READ;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = ST_READ;
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				// wait for the output register to free up
				if (stat.out_free) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

endmodule

// ===== hw/rtl/kvt_datapath.sv =====
// ---------------------------------------------------------------------------
// kvt_datapath
// Configuration registers, key conversion, bit-serial or masked slot reduction,
// table RAM and output register.
// ---------------------------------------------------------------------------
module kvt_datapath #(
	parameter int TABLE_DEPTH = kvt_pkg::TABLE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  kvt_pkg::dp_cmd_t  cmd,
	output kvt_pkg::dp_stat_t stat,
	input  logic [1:0]        in_cmd,
	input  logic [63:0]       key_bits,
	input  logic [63:0]       value_bits,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [63:0]       read_value,
	output logic              collision
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CW    = kvt_pkg::CNT_W;
	// largest power of two not above the depth, minus one
	localparam logic [31:0] SPAN_MASK = (32'd1 << $clog2(TABLE_DEPTH + 1) - 1) - 32'd1;

	logic [CW-1:0] entries_q;
	logic          pow2_q;
	logic [63:0]   null_q;

	logic [1:0]  cmd_q;
	logic [63:0] key_q;
	logic [63:0] val_q;
	logic [63:0] kint_q;
	logic [63:0] dvd_q;
	logic [CW-1:0] rem_q;
	logic [5:0]  cnt_q;
	logic [IDX_W-1:0] slot_q;
	logic [IDX_W-1:0] clr_cnt_q;
	logic        out_valid_q;
	logic [63:0] read_value_q;
	logic        collision_q;

	logic [CW-1:0] n_eff;
	logic [CW-1:0] smear;
	logic [31:0]   mask32;
	logic [31:0]   masked32;
	logic [CW:0]   trial;
	logic [CW-1:0] rem_next;
	logic [31:0]   rem32;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [kvt_pkg::WORD_W-1:0] ram_wdata;
	logic [kvt_pkg::WORD_W-1:0] ram_rdata;
	logic              hit_v;
	logic [63:0]       hit_key;
	logic [63:0]       hit_val;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= kvt_pkg::ENTRIES_RST;
			pow2_q    <= 1'b0;
			null_q    <= 64'd0;
		end else if (cfg_we) begin
			unique case (kvt_pkg::cfg_idx_t'(cfg_index))
				kvt_pkg::CFG_ENTRIES: entries_q <= cfg_data[CW-1:0];
				kvt_pkg::CFG_POW2:    pow2_q    <= cfg_data[0];
				kvt_pkg::CFG_NULL:    null_q    <= cfg_data;
				kvt_pkg::CFG_NONE:    ;
				default:              ;
			endcase
		end
	end

	// effective entry count, clamped to 1..depth
	always_comb begin
		if (entries_q == '0) begin
			n_eff = CW'(1);
		end else if (32'(entries_q) > 32'(TABLE_DEPTH)) begin
			n_eff = CW'(TABLE_DEPTH);
		end else begin
			n_eff = entries_q;
		end
		smear = n_eff - CW'(1);
		smear = smear | (smear >> 1);
		smear = smear | (smear >> 2);
		smear = smear | (smear >> 4);
		smear = smear | (smear >> 8);
		mask32   = 32'(smear) & SPAN_MASK;
		masked32 = kint_q[31:0] & mask32;
		// restoring division step
		trial = {rem_q, dvd_q[63]};
		if (trial >= {1'b0, n_eff}) begin
			rem_next = CW'(trial - {1'b0, n_eff});
		end else begin
			rem_next = trial[CW-1:0];
		end
		rem32 = 32'(rem_next);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_cmd;
			key_q <= key_bits;
			val_q <= value_bits;
		end
		if (cmd.conv) begin
			kint_q <= kvt_pkg::key_to_uint(key_q);
		end
		if (cmd.mask_slot) begin
			slot_q <= masked32[IDX_W-1:0];
		end
		if (cmd.div_start) begin
			dvd_q <= kint_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q  <= {dvd_q[62:0], 1'b0};
			rem_q  <= rem_next;
			slot_q <= rem32[IDX_W-1:0];
		end
		if (cmd.exec) begin
			read_value_q <= 64'd0;
			collision_q  <= 1'b0;
			unique case (kvt_pkg::cmd_t'(cmd_q))
				kvt_pkg::CMD_GET:     read_value_q <= hit_v ? hit_val : null_q;
				kvt_pkg::CMD_GET_CHK: read_value_q <= (hit_v && hit_key == key_q) ?
					hit_val : null_q;
				kvt_pkg::CMD_SET:     collision_q <= hit_v;
				kvt_pkg::CMD_UPDATE:  ;
				default:              ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.div_start) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 6'd1;
			end
			if (cmd.clear) begin
				clr_cnt_q <= clr_cnt_q + IDX_W'(1);
			end
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign {hit_v, hit_key, hit_val} = ram_rdata;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = {1'b1, key_q, val_q};
		if (cmd.clear) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else if (cmd.exec) begin
			ram_we = (kvt_pkg::cmd_t'(cmd_q) == kvt_pkg::CMD_UPDATE) ||
				((kvt_pkg::cmd_t'(cmd_q) == kvt_pkg::CMD_SET) && !hit_v);
		end
	end

	kvt_ram #(
		.WIDTH(kvt_pkg::WORD_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	assign stat.pow2       = pow2_q;
	assign stat.div_last   = (cnt_q == 6'd63);
	assign stat.clear_last = (clr_cnt_q == IDX_W'(TABLE_DEPTH - 1));
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign collision  = collision_q;

endmodule

// ===== hw/rtl/direct_mapped_key_value_table.sv =====
// ---------------------------------------------------------------------------
// direct_mapped_key_value_table
// Direct-mapped table of 64-bit double key/value pairs.
// ---------------------------------------------------------------------------
// After reset the block sweeps the table once, one slot a cycle, clearing the
// valid bits: in_ready stays low during the sweep while configuration writes
// are still taken. Items are then handled one at a time. In modulo mode the
// result register is loaded, once the output register is free, after key
// conversion, slot setup, the bit-serial remainder unit (one quotient bit a
// cycle) and a registered RAM read followed by the write-back. In power-of-two
// mode the slot is masked from the converted key instead. The block is ready
// for the next item in the cycle after the result register is loaded. A
// finished result waits in the output register while the next item is accepted.
module direct_mapped_key_value_table #(
	parameter int TABLE_DEPTH = kvt_pkg::TABLE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [63:0] key_bits,
	input  logic [63:0] value_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] read_value,
	output logic        collision,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	kvt_pkg::dp_cmd_t  dp_cmd;
	kvt_pkg::dp_stat_t dp_stat;

	kvt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	kvt_datapath #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (dp_cmd),
		.stat       (dp_stat),
		.in_cmd     (cmd),
		.key_bits   (key_bits),
		.value_bits (value_bits),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_value (read_value),
		.collision  (collision)
	);

endmodule

// ===== hw/rtl/kvt_checker.sv =====
// ---------------------------------------------------------------------------
// kvt_checker
// Port-level checks for the key/value table, bound to the top level.
// ---------------------------------------------------------------------------
`include "direct_mapped_key_value_table_defines.svh"

module kvt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] read_value,
	input logic        collision
);

	// a collision only comes from a set, which returns zero
	`KVT_ASSERT_NOW(a_collision_zero, out_valid && collision, read_value == 64'd0)
	// one transaction in flight at a time
	`KVT_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
	`KVT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`KVT_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
		$stable(read_value) && $stable(collision))

endmodule

bind direct_mapped_key_value_table kvt_checker u_kvt_checker (.*);

// ===== test/direct_mapped_key_value_table_test.sv =====
// ---------------------------------------------------------------------------
// direct_mapped_key_value_table_test
// Drives random and directed get/set/update transactions through the table,
// predicts each result from a shadow copy of the slots and registers, and
// compares every result transaction in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

class kvt_scoreboard;
	localparam int DEPTH = kvt_pkg::TABLE_DEPTH;
	bit          shadow_valid [DEPTH];
	logic [63:0] shadow_key [DEPTH];
	logic [63:0] shadow_value [DEPTH];
	logic [10:0] entries;
	bit          pow2;
	logic [63:0] null_word;
	logic [63:0] want_value [$];
	bit          want_collision [$];
	int          errors;

	function new();
		entries   = 11'd1024;
		pow2      = 0;
		null_word = '0;
		errors    = 0;
		foreach (shadow_valid[i]) shadow_valid[i] = 0;
	endfunction

	function void write_reg(kvt_pkg::cfg_idx_t idx, logic [63:0] data);
		case (idx)
			kvt_pkg::CFG_ENTRIES: entries = data[10:0];
			kvt_pkg::CFG_POW2:    pow2 = data[0];
			kvt_pkg::CFG_NULL:    null_word = data;
			default: ;
		endcase
	endfunction

	function logic [63:0] key_as_uint(logic [63:0] b);
		logic [10:0] ex;
		logic [63:0] mant;
		int          sh;
		ex   = b[62:52];
		mant = {11'd0, 1'b1, b[51:0]};
		if (ex == 11'h7FF) return (b[51:0] != 0 || b[63]) ? 64'd0 : '1;
		if (b[63] || ex < 11'd1023) return 64'd0;
		sh = int'(ex) - 1023;
		if (sh >= 64) return '1;
		if (sh >= 52) return mant << (sh - 52);
		return mant >> (52 - sh);
	endfunction

	function int slot_index(logic [63:0] b);
		logic [63:0] k;
		longint unsigned n, span;
		k = key_as_uint(b);
		n = entries;
		if (n == 0) n = 1;
		if (n > DEPTH) n = DEPTH;
		if (!pow2) return int'(k % n);
		span = 1;
		while (span < n) span = span << 1;
		while (span > DEPTH) span = span >> 1;
		return int'(k & (span - 1));
	endfunction

	function void note_input(logic [1:0] c, logic [63:0] k, logic [63:0] v);
		int          s;
		logic [63:0] rd;
		bit          col;
		s   = slot_index(k);
		rd  = '0;
		col = 0;
		case (kvt_pkg::cmd_t'(c))
			kvt_pkg::CMD_GET: rd = shadow_valid[s] ? shadow_value[s] : null_word;
			kvt_pkg::CMD_GET_CHK:
				rd = (shadow_valid[s] && shadow_key[s] == k) ? shadow_value[s] : null_word;
			kvt_pkg::CMD_SET: begin
				if (shadow_valid[s]) col = 1;
				else begin
					shadow_valid[s] = 1;
					shadow_key[s]   = k;
					shadow_value[s] = v;
				end
			end
			default: begin
				shadow_valid[s] = 1;
				shadow_key[s]   = k;
				shadow_value[s] = v;
			end
		endcase
		want_value.push_back(rd);
		want_collision.push_back(col);
	endfunction

	function void check_result(logic [63:0] rd, logic col);
		logic [63:0] ev;
		bit          ec;
		if (want_value.size() == 0) begin
			$display("%0t: unexpected result read_value=%h collision=%b", $time, rd, col);
			errors++;
			return;
		end
		ev = want_value.pop_front();
		ec = want_collision.pop_front();
		if (rd !== ev) begin
			$display("%0t: read_value expected %h actual %h", $time, ev, rd);
			errors++;
		end
		if (col !== ec) begin
			$display("%0t: collision expected %b actual %b", $time, ec, col);
			errors++;
		end
	endfunction
endclass

module direct_mapped_key_value_table_test;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	logic [63:0] key_bits;
	logic [63:0] value_bits;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] read_value;
	logic        collision;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	kvt_scoreboard table_model;
	bit            hold_off;

	direct_mapped_key_value_table u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .key_bits(key_bits), .value_bits(value_bits),
		.out_valid(out_valid), .out_ready(out_ready), .read_value(read_value),
		.collision(collision), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("FAIL direct_mapped_key_value_table");
		$finish;
	end

	// double with a small integer value n (n < 2^52)
	function automatic logic [63:0] int_key(longint unsigned n);
		int msb;
		if (n == 0) return 64'd0;
		msb = 0;
		for (int i = 0; i < 64; i++) if (n[i]) msb = i;
		return {1'b0, 11'(1023 + msb), 52'(n << (52 - msb))};
	endfunction

	task automatic send_item(logic [1:0] c, logic [63:0] k, logic [63:0] v);
		table_model.note_input(c, k, v);
		in_valid   <= 1;
		cmd        <= c;
		key_bits   <= k;
		value_bits <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic idle_sender(int n);
		in_valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	task automatic write_cfg(kvt_pkg::cfg_idx_t idx, logic [63:0] data);
		in_valid  <= 0;
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= data;
		table_model.write_reg(idx, data);
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (table_model.want_value.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] rand_key(int span);
		case ($urandom_range(0, 9))
			0: return rand_word();
			1: return {1'b1, 63'(rand_word())};
			2: return {$urandom_range(0, 1) ? 1'b0 : 1'b1, 11'h7FF, 52'(rand_word())};
			3: return {1'b0, 11'($urandom_range(1086, 1150)), 52'(rand_word())};
			4: return {1'b0, 11'($urandom_range(1023, 1085)), 52'(rand_word())};
			default: return int_key($urandom_range(0, span - 1));
		endcase
	endfunction

	task automatic random_phase(int count, int span);
		int burst;
		int n;
		n = 0;
		while (n < count) begin
			burst = $urandom_range(1, 12);
			for (int i = 0; i < burst && n < count; i++) begin
				send_item(2'($urandom_range(0, 3)), rand_key(span), rand_word());
				n++;
			end
			if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 90));
		end
	endtask

	// receiver stall pattern, with one long hold-off on request
	initial begin
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 0;
				repeat (600) @(posedge clk);
				hold_off = 0;
			end else if ($urandom_range(0, 3) == 0)
				out_ready <= 0;
			else
				out_ready <= 1;
		end
	end

	// result monitor
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				table_model.check_result(read_value, collision);
		end
	end

	initial begin
		table_model = new();
		arst_n     = 0;
		in_valid   = 0;
		cmd        = kvt_pkg::CMD_GET;
		key_bits   = '0;
		value_bits = '0;
		cfg_we     = 0;
		cfg_index  = kvt_pkg::CFG_ENTRIES;
		cfg_data   = '0;
		hold_off   = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		write_cfg(kvt_pkg::CFG_NULL, 64'hDEAD_BEEF_0BAD_F00D);
		// directed: conversion corners and every command
		send_item(kvt_pkg::CMD_GET, int_key(5), '0);
		send_item(kvt_pkg::CMD_SET, int_key(5), 64'h1111);
		send_item(kvt_pkg::CMD_SET, int_key(5), 64'h2222);
		send_item(kvt_pkg::CMD_GET, int_key(5), '0);
		send_item(kvt_pkg::CMD_GET_CHK, int_key(5), '0);
		send_item(kvt_pkg::CMD_GET_CHK, int_key(1029), '0);
		send_item(kvt_pkg::CMD_UPDATE, int_key(1029), '1);
		send_item(kvt_pkg::CMD_GET_CHK, int_key(5), '0);
		send_item(kvt_pkg::CMD_SET, 64'hFFF8_0000_0000_0000, 64'h3333);
		send_item(kvt_pkg::CMD_GET_CHK, 64'h7FF8_0000_0000_0001, '0);
		send_item(kvt_pkg::CMD_GET, 64'h8000_0000_0000_0000, '0);
		send_item(kvt_pkg::CMD_UPDATE, 64'h7FF0_0000_0000_0000, 64'h4444);
		send_item(kvt_pkg::CMD_GET, 64'h43F0_0000_0000_0000, '0);
		send_item(kvt_pkg::CMD_GET_CHK, 64'hFFF0_0000_0000_0000, '0);
		send_item(kvt_pkg::CMD_SET, 64'h3FEF_FFFF_FFFF_FFFF, 64'h5555);
		send_item(kvt_pkg::CMD_UPDATE, 64'h433F_FFFF_FFFF_FFFF, '0);
		send_item(kvt_pkg::CMD_GET, 64'h4340_0000_0000_0001, '0);
		drain();

		// pow2 mode with entry count 0 and above the table
		write_cfg(kvt_pkg::CFG_POW2, 64'd1);
		write_cfg(kvt_pkg::CFG_ENTRIES, 64'd0);
		send_item(kvt_pkg::CMD_GET, int_key(7), '0);
		drain();
		write_cfg(kvt_pkg::CFG_ENTRIES, 64'h7FF);
		send_item(kvt_pkg::CMD_GET, int_key(1029), '0);
		send_item(kvt_pkg::CMD_GET, 64'h7FF0_0000_0000_0000, '0);
		drain();
		write_cfg(kvt_pkg::CFG_ENTRIES, 64'd3);
		write_cfg(kvt_pkg::CFG_NONE, 64'd0);
		random_phase(150, 16);
		drain();

		// long receiver hold-off so the block backs up
		hold_off = 1;
		random_phase(40, 64);
		drain();

		write_cfg(kvt_pkg::CFG_POW2, 64'd0);
		write_cfg(kvt_pkg::CFG_ENTRIES, 64'd1);
		write_cfg(kvt_pkg::CFG_NULL, '1);
		random_phase(120, 8);
		drain();
		write_cfg(kvt_pkg::CFG_ENTRIES, 64'd1000);
		write_cfg(kvt_pkg::CFG_NULL, '0);
		random_phase(300, 2048);
		drain();
		write_cfg(kvt_pkg::CFG_ENTRIES, 64'd37);
		write_cfg(kvt_pkg::CFG_NULL, rand_word());
		random_phase(250, 100);
		drain();
		write_cfg(kvt_pkg::CFG_POW2, 64'd1);
		write_cfg(kvt_pkg::CFG_ENTRIES, 64'd1024);
		random_phase(300, 4096);
		drain();

		if (table_model.errors == 0 && table_model.want_value.size() == 0)
			$display("PASS direct_mapped_key_value_table");
		else
			$display("FAIL direct_mapped_key_value_table");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/kvt_pkg.sv
hw/rtl/kvt_ram.sv
hw/rtl/kvt_ctrl.sv
hw/rtl/kvt_datapath.sv
hw/rtl/direct_mapped_key_value_table.sv
hw/rtl/kvt_checker.sv
test/direct_mapped_key_value_table_test.sv
